// ----- rtl/core/radio_frame_packer_checker_assert.svh -----
// ----------------------------------------------------------------------------
// Radio frame packer/checker assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RADIO_FRAME_PACKER_CHECKER_ASSERT_SVH
`define RADIO_FRAME_PACKER_CHECKER_ASSERT_SVH

`ifndef SYNTH
`define RFPC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("rfpc: forbidden condition seen");
`define RFPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rfpc: expected follow-up missing");
`else
`define RFPC_ASSERT_NEVER(label, expr)
`define RFPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/rfpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Radio frame packer/checker package
// Request codes, frame constants and the emit beat type shared by all units.
// ----------------------------------------------------------------------------
package rfpc_pkg;

    localparam logic [1:0] REQ_SEND  = 2'd0;
    localparam logic [1:0] REQ_FLUSH = 2'd1;
    localparam logic [1:0] REQ_RADIO = 2'd2;

    localparam logic [7:0] HDR_MARK      = 8'hA0;
    localparam int         MAX_LEN       = 30;
    localparam logic [4:0] LIMIT_RESET   = 5'd30;
    localparam logic [1:0] ADDR_LIMIT    = 2'd0;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       port;
        logic       last;
    } t_emit;

endpackage

// ----- rtl/core/rfpc_send.sv -----
// ----------------------------------------------------------------------------
// Transmit queue and frame builder
// Byte queue in a one-port-read memory; sums the payload in one pass, then
// streams header, checksum and payload in a second pass.
// ----------------------------------------------------------------------------
module rfpc_send
    import rfpc_pkg::*;
#(
    parameter int FRAME_BYTES = 32,
    parameter int QUEUE_DEPTH = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_flush,
    input  logic [7:0] i_byte,
    input  logic [4:0] i_limit,
    input  logic       i_out_free,
    output logic       o_idle,
    output t_emit      o_emit
);

    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MaxPay0 = (MAX_LEN < FRAME_BYTES - 2) ? MAX_LEN : FRAME_BYTES - 2;
    localparam int MaxPay  = (MaxPay0 < QUEUE_DEPTH - 1) ? MaxPay0 : QUEUE_DEPTH - 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_HDR  = 5'b00100,
        S_CSUM = 5'b01000,
        S_DATA = 5'b10000
    } t_send_state;

    t_send_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [HW-1:0] r_head, n_head;
    logic [HW-1:0] r_ptr, n_ptr;
    logic [4:0]    r_n, n_n;
    logic [4:0]    r_idx, n_idx;
    logic [7:0]    r_sum, n_sum;
    logic          r_pend, n_pend;
    logic [7:0]    r_mem [QUEUE_DEPTH];
    logic [7:0]    r_rdata;

    logic          we, re;
    logic [HW-1:0] waddr, raddr;
    logic [4:0]    lim;
    logic [5:0]    tail_sum;
    logic [CW-1:0] cnt_ins;
    logic          data_last;

    function automatic logic [HW-1:0] f_inc(input logic [HW-1:0] p);
        return (p == HW'(QUEUE_DEPTH - 1)) ? '0 : p + HW'(1);
    endfunction

    always_comb begin
        if (i_limit == 5'd0) begin
            lim = 5'd1;
        end else if (i_limit > 5'(MaxPay)) begin
            lim = 5'(MaxPay);
        end else begin
            lim = i_limit;
        end
        tail_sum = 6'(r_head) + 6'(r_count);
        if (tail_sum >= 6'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - 6'(QUEUE_DEPTH);
        end
        waddr   = HW'(tail_sum);
        cnt_ins = (6'(r_count) < 6'(QUEUE_DEPTH)) ? r_count + CW'(1) : r_count;
        data_last = ((r_idx + 5'd1) == r_n);
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_head  = r_head;
        n_ptr   = r_ptr;
        n_n     = r_n;
        n_idx   = r_idx;
        n_sum   = r_sum;
        n_pend  = r_pend;
        we      = 1'b0;
        re      = 1'b0;
        raddr   = r_head;
        o_emit  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ptr  = r_head;
                    n_idx  = 5'd0;
                    n_sum  = 8'd0;
                    n_pend = 1'b0;
                    if (!i_flush) begin
                        we      = (6'(r_count) < 6'(QUEUE_DEPTH));
                        n_count = cnt_ins;
                        if (6'(cnt_ins) > 6'(lim)) begin
                            n_n     = lim;
                            n_state = S_SUM;
                        end
                    end else begin
                        n_n     = (6'(r_count) > 6'(lim)) ? lim : 5'(r_count);
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (r_pend) begin
                    n_sum = r_sum + r_rdata;
                end
                if (r_idx != r_n) begin
                    re     = 1'b1;
                    raddr  = r_ptr;
                    n_ptr  = f_inc(r_ptr);
                    n_idx  = r_idx + 5'd1;
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                // prefetch the first payload byte while the header goes out
                re = 1'b1;
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.data  = HDR_MARK | {3'b000, r_n};
                    n_idx        = 5'd0;
                    n_state      = S_CSUM;
                end
            end
            S_CSUM: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.data  = r_sum;
                    o_emit.last  = (r_n == 5'd0);
                    n_state      = (r_n == 5'd0) ? S_IDLE : S_DATA;
                end
            end
            S_DATA: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.data  = r_rdata;
                    o_emit.last  = data_last;
                    n_head       = f_inc(r_head);
                    n_idx        = r_idx + 5'd1;
                    if (data_last) begin
                        n_count = CW'(6'(r_count) - 6'(r_n));
                        n_state = S_IDLE;
                    end else begin
                        re    = 1'b1;
                        raddr = f_inc(r_head);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_n   <= n_n;
        r_idx <= n_idx;
        r_sum <= n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= i_byte;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

endmodule

// ----- rtl/core/rfpc_recv.sv -----
// ----------------------------------------------------------------------------
// Receive frame buffer and checker
// Stores one radio frame, keeps header, checksum and a running payload sum
// in registers, then streams a good payload out of the frame memory.
// ----------------------------------------------------------------------------
module rfpc_recv
    import rfpc_pkg::*;
#(
    parameter int FRAME_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_byte,
    input  logic       i_out_free,
    output logic       o_idle,
    output t_emit      o_emit
);

    localparam int PW     = $clog2(FRAME_BYTES);
    localparam int MaxLen = (MAX_LEN < FRAME_BYTES - 2) ? MAX_LEN : FRAME_BYTES - 2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } t_recv_state;

    t_recv_state   r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [7:0]    r_hdr, n_hdr;
    logic [7:0]    r_csum, n_csum;
    logic [7:0]    r_sum, n_sum;
    logic [4:0]    r_len, n_len;
    logic [PW-1:0] r_raddr, n_raddr;
    logic [7:0]    r_mem [FRAME_BYTES];
    logic [7:0]    r_rdata;

    logic          we, re;
    logic [PW-1:0] raddr;
    logic [4:0]    len_in;
    logic          in_payload;
    logic [7:0]    sum_new;
    logic          frame_ok;
    logic          out_last;

    always_comb begin
        len_in     = r_hdr[4:0];
        in_payload = (6'(r_pos) >= 6'd2) && (6'(r_pos) < (6'(len_in) + 6'd2));
        sum_new    = in_payload ? r_sum + i_byte : r_sum;
        frame_ok   = r_hdr[7] && r_hdr[5] && (6'(len_in) <= 6'(MaxLen))
                     && (sum_new == r_csum) && (len_in != 5'd0);
        out_last   = (6'(r_raddr) == (6'(r_len) + 6'd1));
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_hdr   = r_hdr;
        n_csum  = r_csum;
        n_sum   = r_sum;
        n_len   = r_len;
        n_raddr = r_raddr;
        we      = 1'b0;
        re      = 1'b0;
        raddr   = r_raddr;
        o_emit  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    we = 1'b1;
                    if (r_pos == '0) begin
                        n_hdr = i_byte;
                        n_sum = 8'd0;
                    end else if (r_pos == PW'(1)) begin
                        n_csum = i_byte;
                    end else begin
                        n_sum = sum_new;
                    end
                    if (r_pos == PW'(FRAME_BYTES - 1)) begin
                        n_pos = '0;
                        // drop bad frames silently
                        if (frame_ok) begin
                            n_len   = len_in;
                            re      = 1'b1;
                            raddr   = PW'(2);
                            n_raddr = PW'(2);
                            n_state = S_OUT;
                        end
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.data  = r_rdata;
                    o_emit.port  = 1'b1;
                    o_emit.last  = out_last;
                    if (out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        re      = 1'b1;
                        raddr   = r_raddr + PW'(1);
                        n_raddr = r_raddr + PW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr   <= n_hdr;
        r_csum  <= n_csum;
        r_sum   <= n_sum;
        r_len   <= n_len;
        r_raddr <= n_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_pos] <= i_byte;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

endmodule

// ----- rtl/core/radio_frame_packer_checker.sv -----
// ----------------------------------------------------------------------------
// Radio frame packer/checker
// Serial-to-radio frame builder and radio-to-serial frame checker.
// ----------------------------------------------------------------------------
// One item is taken at a time. A serial byte that does not fill a frame and a
// radio byte that does not end a frame are taken while the block stays idle. A
// flush, or a serial byte that pushes the queue past the payload limit, first
// sums the n payload bytes through the single read port of the queue memory,
// then sends n + 2 output beats (header, checksum, payload). The last byte of
// a good radio frame is followed by one beat per payload byte read from the
// frame memory. A result beat waits in the output register, so the next item
// may be taken while it is still pending.
`include "radio_frame_packer_checker_assert.svh"

module radio_frame_packer_checker
    import rfpc_pkg::*;
#(
    parameter int FRAME_BYTES = 32,
    parameter int QUEUE_DEPTH = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] out_port
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_mvalid;
    logic [7:0] r_mdata;
    logic       r_mport;
    logic       r_mlast;
    logic [4:0] r_limit;

    logic       w_accept;
    logic       w_out_free;
    logic       w_send_idle;
    logic       w_recv_idle;
    t_emit      w_send_emit;
    t_emit      w_recv_emit;
    t_emit      w_emit;

    assign s_axis_tready = w_send_idle && w_recv_idle;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_mvalid || m_axis_tready;
    assign w_emit        = w_send_emit.valid ? w_send_emit : w_recv_emit;

    rfpc_send #(
        .FRAME_BYTES (FRAME_BYTES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_send (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && (s_axis_tuser == REQ_SEND || s_axis_tuser == REQ_FLUSH)),
        .i_flush    (s_axis_tuser == REQ_FLUSH),
        .i_byte     (s_axis_tdata),
        .i_limit    (r_limit),
        .i_out_free (w_out_free),
        .o_idle     (w_send_idle),
        .o_emit     (w_send_emit)
    );

    rfpc_recv #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_recv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && (s_axis_tuser == REQ_RADIO)),
        .i_byte     (s_axis_tdata),
        .i_out_free (w_out_free),
        .o_idle     (w_recv_idle),
        .o_emit     (w_recv_emit)
    );

    // output register: load a new beat or drop the one just taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_emit.valid) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_mdata <= w_emit.data;
            r_mport <= w_emit.port;
            r_mlast <= w_emit.last;
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_mport;
    assign m_axis_tlast  = r_mlast;

    // payload limit register at byte address zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_LIMIT)) begin
            r_limit <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {27'd0, r_limit};

    `RFPC_ASSERT_NEVER(a_single_emitter, w_send_emit.valid && w_recv_emit.valid)
    `RFPC_ASSERT_NEVER(a_no_overwrite, w_emit.valid && r_mvalid && !m_axis_tready)
    `RFPC_ASSERT_NEXT(a_flush_builds_frame, w_accept && (s_axis_tuser == REQ_FLUSH), !w_send_idle)

endmodule

// ----- test/radio_frame_packer_checker_test.sv -----
// ----------------------------------------------------------------------------
// Radio frame packer/checker testbench
// Sends serial bytes, idle flushes and radio frame bytes into the block,
// predicts every emitted beat with a scoreboard model of the send queue and
// the receive frame, and compares each output beat field by field. The run
// moves through several payload limits and ready/valid idling patterns.
// ----------------------------------------------------------------------------
module radio_frame_packer_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfpc_pkg::*;

    localparam int         FRAME_LEN    = 32;
    localparam int         QUEUE_LEN    = 31;
    localparam logic [7:0] LEN_MASK     = 8'h1F;
    localparam logic [1:0] REQ_NONE     = 2'd3;    // reserved code, no effect
    localparam logic [1:0] LIMIT_ADDR   = 2'd0;
    localparam int         DRAIN_CYCLES = 80;
    localparam int         CYCLE_LIMIT  = 800000;
    localparam int         PHASE_ITEMS  = 30;

    typedef struct packed {
        logic [7:0] data;
        logic       port;
        logic       last;
    } out_beat_t;

    typedef enum int {
        FRAME_GOOD,
        FRAME_EMPTY,
        FRAME_FULL,
        FRAME_BAD_MARK,
        FRAME_BAD_LEN,
        FRAME_BAD_SUM
    } frame_kind_e;

    class frame_scoreboard;
        logic [7:0]  tx_queue [QUEUE_LEN];
        int unsigned tx_count;
        int unsigned tx_head;
        logic [7:0]  rx_frame [FRAME_LEN];
        int unsigned rx_pos;
        logic [4:0]  limit_reg;
        out_beat_t   pending_beats [$];
        int unsigned errors;

        function new();
            tx_count  = 0;
            tx_head   = 0;
            rx_pos    = 0;
            limit_reg = LIMIT_RESET;
            errors    = 0;
        endfunction

        function void set_limit(logic [31:0] value);
            limit_reg = value[4:0];
        endfunction

        function int unsigned frame_limit();
            int unsigned lim;
            lim = limit_reg;
            if (lim < 1) lim = 1;
            if (lim > MAX_LEN) lim = MAX_LEN;
            return lim;
        endfunction

        function void push_beat(logic [7:0] data, logic port, logic last);
            out_beat_t b;
            b.data = data;
            b.port = port;
            b.last = last;
            pending_beats.push_back(b);
        endfunction

        // Header, checksum, then n payload bytes popped from the queue head.
        function void pack_frame(int unsigned n);
            logic [7:0]  sum;
            int unsigned pos;
            int unsigned i;
            sum = 8'h00;
            pos = tx_head;
            for (i = 0; i < n; i++) begin
                sum += tx_queue[pos];
                pos = (pos + 1) % QUEUE_LEN;
            end
            push_beat(HDR_MARK | (8'(n) & LEN_MASK), 1'b0, 1'b0);
            push_beat(sum, 1'b0, n == 0);
            for (i = 0; i < n; i++) begin
                push_beat(tx_queue[tx_head], 1'b0, i + 1 == n);
                tx_head = (tx_head + 1) % QUEUE_LEN;
            end
            tx_count -= n;
        endfunction

        // Forward the payload only when marker, length and checksum hold.
        function void unpack_frame();
            logic [7:0]  hdr;
            logic [7:0]  sum;
            int unsigned len;
            int unsigned i;
            hdr = rx_frame[0];
            len = hdr & LEN_MASK;
            if ((hdr & HDR_MARK) != HDR_MARK) return;
            if (len > MAX_LEN) return;
            sum = 8'h00;
            for (i = 0; i < len; i++) sum += rx_frame[i + 2];
            if (sum != rx_frame[1]) return;
            for (i = 0; i < len; i++) push_beat(rx_frame[i + 2], 1'b1, i + 1 == len);
        endfunction

        function void note_item(logic [1:0] req, logic [7:0] data);
            case (req)
                REQ_SEND: begin
                    if (tx_count < QUEUE_LEN) begin
                        tx_queue[(tx_head + tx_count) % QUEUE_LEN] = data;
                        tx_count++;
                    end
                    if (tx_count > frame_limit()) pack_frame(frame_limit());
                end
                REQ_FLUSH: begin
                    pack_frame(tx_count > frame_limit() ? frame_limit() : tx_count);
                end
                REQ_RADIO: begin
                    rx_frame[rx_pos] = data;
                    rx_pos++;
                    if (rx_pos >= FRAME_LEN) begin
                        rx_pos = 0;
                        unpack_frame();
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_beat(logic [7:0] data, logic port, logic last);
            out_beat_t want;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, actual data %02h port %0d last %0d",
                         $time, data, port, last);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            if (want.data !== data) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
                errors++;
            end
            if (want.port !== port) begin
                $display("%0t: out_port expected %0d actual %0d", $time, want.port, port);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: out_last expected %0d actual %0d", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] in_byte
    logic [1:0]  s_axis_tuser;     // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // [7:0] out_byte
    logic        m_axis_tuser;     // [0] out_port
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     items_sent     = 0;
    int unsigned     cycle_count    = 0;

    radio_frame_packer_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_item(input logic [1:0] req, input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = data;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(req, data);
        if (req != REQ_NONE) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending_beats.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        wait_drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = LIMIT_ADDR;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_limit(value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_radio_frame(input frame_kind_e kind);
        logic [7:0]  body [FRAME_LEN];
        logic [7:0]  sum;
        logic [1:0]  mark_sel;
        int unsigned len;
        int unsigned i;
        // finish any partial frame so this one lines up
        while (sb.rx_pos != 0) send_item(REQ_RADIO, 8'($urandom));
        case (kind)
            FRAME_EMPTY: len = 0;
            FRAME_FULL:  len = MAX_LEN;
            default:     len = $urandom_range(1, MAX_LEN);
        endcase
        for (i = 0; i < FRAME_LEN; i++) body[i] = 8'($urandom);
        sum = 8'h00;
        for (i = 0; i < len; i++) sum += body[i + 2];
        body[0] = {1'b1, body[0][6], 1'b1, 5'(len)};
        body[1] = sum;
        case (kind)
            FRAME_BAD_MARK: begin
                mark_sel = 2'($urandom_range(1, 3));
                if (mark_sel[0]) body[0][7] = 1'b0;
                if (mark_sel[1]) body[0][5] = 1'b0;
            end
            FRAME_BAD_LEN: body[0][4:0] = 5'h1F;
            FRAME_BAD_SUM: body[1] = sum + 8'($urandom_range(1, 255));
            default: ;
        endcase
        for (i = 0; i < FRAME_LEN; i++) send_item(REQ_RADIO, body[i]);
    endtask

    initial begin
        int          phase;
        int          seq;
        int unsigned pick;
        int unsigned frames_sent;
        frame_kind_e kind;

        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = REQ_SEND;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = LIMIT_ADDR;
        pwdata        = 32'h0;
        frames_sent   = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reserved request code, flush of an empty queue, small flushes
        send_item(REQ_NONE, 8'h00);
        send_item(REQ_NONE, 8'hFF);
        send_item(REQ_FLUSH, 8'h00);
        send_item(REQ_SEND, 8'h00);
        send_item(REQ_SEND, 8'hFF);
        send_item(REQ_SEND, 8'h80);
        send_item(REQ_FLUSH, 8'hFF);
        // a limit of zero behaves as one
        write_limit(32'd0);
        send_item(REQ_SEND, 8'h55);
        send_item(REQ_SEND, 8'hAA);
        send_item(REQ_FLUSH, 8'h00);
        send_item(REQ_FLUSH, 8'h00);
        write_limit(32'd1);
        send_item(REQ_SEND, 8'hFF);
        send_item(REQ_SEND, 8'h01);
        send_item(REQ_FLUSH, 8'h00);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_limit(32'd31);      // above range, acts as the maximum
                end
                1: begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                    write_limit($urandom_range(1, 8));
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                    write_limit(32'd30);
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                    write_limit($urandom_range(0, 29));
                end
            endcase
            items_sent = 0;
            seq        = 0;
            while (items_sent < PHASE_ITEMS) begin
                if (seq == 3) wait_drain();   // hold off until every beat is out
                pick = $urandom_range(99);
                if (pick < 35) begin
                    repeat ($urandom_range(1, 20)) send_item(REQ_SEND, 8'($urandom));
                end else if (pick < 50) begin
                    send_item(REQ_FLUSH, 8'($urandom));
                end else if (pick < 90) begin
                    if (frames_sent < 6)
                        kind = frame_kind_e'(frames_sent);
                    else if (pick < 80)
                        kind = frame_kind_e'($urandom_range(FRAME_GOOD, FRAME_FULL));
                    else
                        kind = frame_kind_e'($urandom_range(FRAME_BAD_MARK, FRAME_BAD_SUM));
                    send_radio_frame(kind);
                    frames_sent++;
                end else if (pick < 95) begin
                    // stray radio bytes break frame alignment
                    repeat ($urandom_range(1, 5)) send_item(REQ_RADIO, 8'($urandom));
                end else begin
                    send_item(REQ_NONE, 8'($urandom));
                end
                seq++;
            end
        end

        wait_drain();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rfpc_pkg.sv
rtl/core/rfpc_send.sv
rtl/core/rfpc_recv.sv
rtl/core/radio_frame_packer_checker.sv
test/radio_frame_packer_checker_test.sv
